>>> design/gpos_pkg.sv
// shared types, constants and register map for the grid position block
package gpos_pkg;

    localparam int CNT_W      = 8;
    localparam int COORD_W    = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = COORD_W;
    localparam int DEN_W      = 2 * CNT_W;
    localparam int DIV_W      = COORD_W + DEN_W;
    localparam int PROD_W     = DEN_W + COORD_W + 2;
    localparam int NUM_W      = PROD_W + 2;
    localparam int DIV_STEPS  = COORD_W;
    localparam int LANES      = 2;

    localparam logic [CNT_W-1:0] MIN_COUNT = CNT_W'(2);

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_COL_CORNER_X = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_COL_CORNER_Y = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_CORNER_X = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_CORNER_Y = CFG_IDX_W'(7);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SMALL   = 2'd1,
        ST_OUTSIDE = 2'd2,
        ST_SAT     = 2'd3
    } status_t;

    typedef struct packed {
        logic [CNT_W-1:0]   row_count;
        logic [CNT_W-1:0]   col_count;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [COORD_W-1:0] col_corner_x;
        logic [COORD_W-1:0] col_corner_y;
        logic [COORD_W-1:0] row_corner_x;
        logic [COORD_W-1:0] row_corner_y;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] cell_row;
        logic [CNT_W-1:0] cell_col;
        status_t          code;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

>>> design/gpos_front.sv
// front end: configuration registers, item accept and classification
module gpos_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [gpos_pkg::CNT_W-1:0]          cell_row,
    input  logic [gpos_pkg::CNT_W-1:0]          cell_col,
    input  logic                                cfg_we,
    input  logic [gpos_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gpos_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  gpos_pkg::queue_stat_t               q_stat,
    output logic                                busy,
    output logic                                push,
    output gpos_pkg::item_t                     push_item,
    output gpos_pkg::cfg_t                      cfg
);

    gpos_pkg::cfg_t cfg_reg;
    gpos_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                gpos_pkg::REG_ROW_COUNT:
                    cfg_next.row_count = cfg_data[gpos_pkg::CNT_W-1:0];
                gpos_pkg::REG_COL_COUNT:
                    cfg_next.col_count = cfg_data[gpos_pkg::CNT_W-1:0];
                gpos_pkg::REG_ORIGIN_X:     cfg_next.origin_x     = cfg_data;
                gpos_pkg::REG_ORIGIN_Y:     cfg_next.origin_y     = cfg_data;
                gpos_pkg::REG_COL_CORNER_X: cfg_next.col_corner_x = cfg_data;
                gpos_pkg::REG_COL_CORNER_Y: cfg_next.col_corner_y = cfg_data;
                gpos_pkg::REG_ROW_CORNER_X: cfg_next.row_corner_x = cfg_data;
                gpos_pkg::REG_ROW_CORNER_Y: cfg_next.row_corner_y = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{row_count:    gpos_pkg::MIN_COUNT,
                         col_count:    gpos_pkg::MIN_COUNT,
                         origin_x:     '0,
                         origin_y:     '0,
                         col_corner_x: '0,
                         col_corner_y: '0,
                         row_corner_x: '0,
                         row_corner_y: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classify: grid too small first, then index outside grid
    always_comb
    begin
        push_item.cell_row = cell_row;
        push_item.cell_col = cell_col;
        if (cfg_reg.row_count < gpos_pkg::MIN_COUNT || cfg_reg.col_count < gpos_pkg::MIN_COUNT)
            push_item.code = gpos_pkg::ST_SMALL;
        else if (cell_row >= cfg_reg.row_count || cell_col >= cfg_reg.col_count)
            push_item.code = gpos_pkg::ST_OUTSIDE;
        else
            push_item.code = gpos_pkg::ST_OK;
    end

    assign busy = q_stat.full;
    assign push = start && !q_stat.full;
    assign cfg  = cfg_reg;

endmodule

>>> design/gpos_queue.sv
// two-entry item queue between front and back
module gpos_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  gpos_pkg::item_t       push_item,
    input  logic                  pop,
    output gpos_pkg::item_t       head,
    output gpos_pkg::queue_stat_t q_stat
);

    gpos_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            do_pop;

    assign do_pop = pop && (count_reg != 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);

endmodule

>>> design/gpos_div.sv
// pipelined restoring divider, one quotient bit per stage
module gpos_div
(
    input  logic                          clk,
    input  logic [gpos_pkg::DIV_W-1:0]    rem_in,
    input  logic [gpos_pkg::DEN_W-1:0]    den_in,
    output logic [gpos_pkg::COORD_W-1:0]  quo_out
);

    logic [gpos_pkg::DIV_W-1:0]   rem_reg [gpos_pkg::DIV_STEPS];
    logic [gpos_pkg::DEN_W-1:0]   den_reg [gpos_pkg::DIV_STEPS];
    logic [gpos_pkg::COORD_W-1:0] quo_reg [gpos_pkg::DIV_STEPS];

    genvar gi;
    generate
        for (gi = 0; gi < gpos_pkg::DIV_STEPS; gi++)
        begin : g_step
            localparam int SH = gpos_pkg::DIV_STEPS - 1 - gi;
            logic [gpos_pkg::DIV_W-1:0]   rem_prev;
            logic [gpos_pkg::DEN_W-1:0]   den_prev;
            logic [gpos_pkg::COORD_W-1:0] quo_prev;
            logic [gpos_pkg::DIV_W-1:0]   trial;
            logic                         fits;

            if (gi == 0)
            begin : g_first
                assign rem_prev = rem_in;
                assign den_prev = den_in;
                assign quo_prev = '0;
            end
            else
            begin : g_rest
                assign rem_prev = rem_reg[gi-1];
                assign den_prev = den_reg[gi-1];
                assign quo_prev = quo_reg[gi-1];
            end

            assign trial = gpos_pkg::DIV_W'(den_prev) << SH;
            assign fits  = (rem_prev >= trial);

            always_ff @(posedge clk)
            begin
                rem_reg[gi] <= fits ? (rem_prev - trial) : rem_prev;
                den_reg[gi] <= den_prev;
                quo_reg[gi] <= {quo_prev[gpos_pkg::COORD_W-2:0], fits};
            end
        end
    endgenerate

    assign quo_out = quo_reg[gpos_pkg::DIV_STEPS-1];

endmodule

>>> design/gpos_back.sv
// back end: products, exact numerator, sign and range flags, division, result
module gpos_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  gpos_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    input  gpos_pkg::item_t               in_item,
    output logic                          done,
    output logic [gpos_pkg::COORD_W-1:0]  pos_x,
    output logic [gpos_pkg::COORD_W-1:0]  pos_y,
    output logic [1:0]                    status
);

    localparam int L  = gpos_pkg::LANES;
    localparam int CW = gpos_pkg::COORD_W;

    typedef struct packed {
        gpos_pkg::status_t code;
        logic [L-1:0]      neg;
        logic [L-1:0]      low;
        logic [L-1:0]      high;
    } side_t;

    // stage 1
    logic                          v1_reg;
    gpos_pkg::status_t             code1_reg;
    logic [gpos_pkg::DEN_W-1:0]    den1_reg, rc1_reg, cr1_reg;
    logic signed [CW:0]            span_r1_reg [L];
    logic signed [CW:0]            span_c1_reg [L];
    logic [CW-1:0]                 base1_reg [L];
    // stage 2
    logic                          v2_reg;
    gpos_pkg::status_t             code2_reg;
    logic [gpos_pkg::DEN_W-1:0]    den2_reg;
    logic signed [gpos_pkg::PROD_W-1:0] t1_2_reg [L];
    logic signed [gpos_pkg::PROD_W-1:0] t2_2_reg [L];
    logic [gpos_pkg::DIV_W-1:0]    t3_2_reg [L];
    // stage 3
    logic                          v3_reg;
    gpos_pkg::status_t             code3_reg;
    logic [gpos_pkg::DEN_W-1:0]    den3_reg;
    logic signed [gpos_pkg::NUM_W-1:0] num3_reg [L];
    // stage 4
    logic                          v4_reg;
    side_t                         side4_reg;
    logic [gpos_pkg::DEN_W-1:0]    den4_reg;
    logic [gpos_pkg::DIV_W-1:0]    mag4_reg [L];
    // divider side line
    logic                          sv_reg   [gpos_pkg::DIV_STEPS];
    side_t                         side_reg [gpos_pkg::DIV_STEPS];
    // output
    logic                          done_reg;
    logic [CW-1:0]                 pos_x_reg, pos_y_reg;
    gpos_pkg::status_t             status_reg;

    logic [gpos_pkg::CNT_W-1:0]    rs, cs;
    logic [CW-1:0]                 base_sel [L];
    logic [CW-1:0]                 col_sel  [L];
    logic [CW-1:0]                 row_sel  [L];
    logic [CW-1:0]                 quo      [L];
    logic [gpos_pkg::NUM_W-1:0]    absval   [L];
    side_t                         side4_next;
    side_t                         side_last;
    logic [CW-1:0]                 pos_next [L];
    logic                          clamped;
    gpos_pkg::status_t             status_next;

    assign rs = cfg.row_count - gpos_pkg::CNT_W'(1);
    assign cs = cfg.col_count - gpos_pkg::CNT_W'(1);
    assign base_sel[0] = cfg.origin_x;
    assign base_sel[1] = cfg.origin_y;
    assign col_sel[0]  = cfg.col_corner_x;
    assign col_sel[1]  = cfg.col_corner_y;
    assign row_sel[0]  = cfg.row_corner_x;
    assign row_sel[1]  = cfg.row_corner_y;

    always_ff @(posedge clk)
    begin
        code1_reg <= in_item.code;
        den1_reg  <= gpos_pkg::DEN_W'(rs) * gpos_pkg::DEN_W'(cs);
        rc1_reg   <= gpos_pkg::DEN_W'(in_item.cell_row) * gpos_pkg::DEN_W'(cs);
        cr1_reg   <= gpos_pkg::DEN_W'(in_item.cell_col) * gpos_pkg::DEN_W'(rs);
        for (int i = 0; i < L; i++)
        begin
            base1_reg[i]   <= base_sel[i];
            span_r1_reg[i] <= $signed({1'b0, row_sel[i]}) - $signed({1'b0, base_sel[i]});
            span_c1_reg[i] <= $signed({1'b0, col_sel[i]}) - $signed({1'b0, base_sel[i]});
        end

        code2_reg <= code1_reg;
        den2_reg  <= den1_reg;
        for (int i = 0; i < L; i++)
        begin
            t1_2_reg[i] <= $signed({1'b0, rc1_reg}) * span_r1_reg[i];
            t2_2_reg[i] <= $signed({1'b0, cr1_reg}) * span_c1_reg[i];
            t3_2_reg[i] <= gpos_pkg::DIV_W'(base1_reg[i]) * gpos_pkg::DIV_W'(den1_reg);
        end

        code3_reg <= code2_reg;
        den3_reg  <= den2_reg;
        for (int i = 0; i < L; i++)
        begin
            num3_reg[i] <= gpos_pkg::NUM_W'(t1_2_reg[i]) + gpos_pkg::NUM_W'(t2_2_reg[i])
                         + $signed(gpos_pkg::NUM_W'(t3_2_reg[i]));
        end

        side4_reg <= side4_next;
        den4_reg  <= den3_reg;
        for (int i = 0; i < L; i++)
            mag4_reg[i] <= absval[i][gpos_pkg::DIV_W-1:0];

        side_reg[0] <= side4_reg;
        for (int k = 1; k < gpos_pkg::DIV_STEPS; k++)
            side_reg[k] <= side_reg[k-1];

        pos_x_reg  <= pos_next[0];
        pos_y_reg  <= pos_next[1];
        status_reg <= status_next;
    end

    // sign, magnitude, and out-of-range flags
    always_comb
    begin
        side4_next.code = code3_reg;
        for (int i = 0; i < L; i++)
        begin
            side4_next.neg[i]  = num3_reg[i][gpos_pkg::NUM_W-1];
            absval[i]          = side4_next.neg[i] ? gpos_pkg::NUM_W'(-num3_reg[i])
                                                   : gpos_pkg::NUM_W'(num3_reg[i]);
            side4_next.low[i]  = side4_next.neg[i]
                               && (absval[i] >= gpos_pkg::NUM_W'(den3_reg));
            side4_next.high[i] = !side4_next.neg[i]
                               && (absval[i] >= (gpos_pkg::NUM_W'(den3_reg) << CW));
        end
    end

    genvar gl;
    generate
        for (gl = 0; gl < L; gl++)
        begin : g_lane
            gpos_div u_div
            (
                .clk     (clk),
                .rem_in  (mag4_reg[gl]),
                .den_in  (den4_reg),
                .quo_out (quo[gl])
            );
        end
    endgenerate

    assign side_last = side_reg[gpos_pkg::DIV_STEPS-1];

    always_comb
    begin
        clamped = 1'b0;
        for (int i = 0; i < L; i++)
        begin
            if (side_last.code != gpos_pkg::ST_OK || side_last.neg[i])
                pos_next[i] = '0;
            else if (side_last.high[i])
                pos_next[i] = '1;
            else
                pos_next[i] = quo[i];
            clamped = clamped | side_last.low[i] | side_last.high[i];
        end
        if (side_last.code != gpos_pkg::ST_OK)
            status_next = side_last.code;
        else if (clamped)
            status_next = gpos_pkg::ST_SAT;
        else
            status_next = gpos_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int k = 0; k < gpos_pkg::DIV_STEPS; k++)
                sv_reg[k] <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            sv_reg[0] <= v4_reg;
            for (int k = 1; k < gpos_pkg::DIV_STEPS; k++)
                sv_reg[k] <= sv_reg[k-1];
            done_reg  <= sv_reg[gpos_pkg::DIV_STEPS-1];
        end
    end

    assign done   = done_reg;
    assign pos_x  = pos_x_reg;
    assign pos_y  = pos_y_reg;
    assign status = status_reg;

endmodule

>>> design/three_point_grid_position.sv
// top level of the parallelogram grid position block
//
// Items enter on start with cell_row and cell_col and are taken at any edge
// where start is high and busy is low. Each item gives one result on pos_x,
// pos_y and status, shown for one cycle with done high; the receiver cannot
// stall, so results are never held.
// Configuration is a plain write port: cfg_we, cfg_index, cfg_data. Write it
// only while no item is in flight; unknown indexes are ignored.
// From the accepting edge to the result the item passes the queue, a stage of
// small products, one of span products, one of the numerator sum, one of sign
// and range flags, 16 divider stages (one quotient bit each) and the output
// register.
// Throughput is one item per cycle; the back end never stalls, so the queue
// holds at most one item and busy stays low.
// Reset clears the pipeline valids and the queue, sets both counts to two
// and all corner coordinates to zero.
module three_point_grid_position
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [gpos_pkg::CNT_W-1:0]          cell_row,
    input  logic [gpos_pkg::CNT_W-1:0]          cell_col,
    output logic                                done,
    output logic [gpos_pkg::COORD_W-1:0]        pos_x,
    output logic [gpos_pkg::COORD_W-1:0]        pos_y,
    output logic [1:0]                          status,
    input  logic                                cfg_we,
    input  logic [gpos_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gpos_pkg::CFG_DATA_W-1:0]     cfg_data
);

    gpos_pkg::queue_stat_t q_stat;
    gpos_pkg::item_t       push_item;
    gpos_pkg::item_t       head;
    gpos_pkg::cfg_t        cfg;
    logic                  push;

    gpos_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .busy      (busy),
        .push      (push),
        .push_item (push_item),
        .cfg       (cfg)
    );

    gpos_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (1'b1),
        .head      (head),
        .q_stat    (q_stat)
    );

    gpos_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (!q_stat.empty),
        .in_item  (head),
        .done     (done),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .status   (status)
    );

endmodule

>>> design/gpos_checker.sv
// port-level checks for the grid position block, with its bind
module gpos_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [gpos_pkg::CNT_W-1:0]          cell_row,
    input logic [gpos_pkg::CNT_W-1:0]          cell_col,
    input logic                                done,
    input logic [gpos_pkg::COORD_W-1:0]        pos_x,
    input logic [gpos_pkg::COORD_W-1:0]        pos_y,
    input logic [1:0]                          status,
    input logic                                cfg_we,
    input logic [gpos_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [gpos_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LATENCY = 22;

    logic accept;
    assign accept = start && !busy;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("front stalled");

    a_item_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("item lost");

    a_done_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without item");

    a_fixed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == gpos_pkg::ST_SMALL || status == gpos_pkg::ST_OUTSIDE)
        |-> pos_x == '0 && pos_y == '0)
        else $error("rejected item with nonzero position");

endmodule

bind three_point_grid_position gpos_checker u_gpos_checker (.*);

>>> sim/tb.sv
// testbench for the grid position block: directed and random cells checked against a predictor
`timescale 1ns / 100ps

module tb;
    import gpos_pkg::*;

    localparam int LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [CNT_W-1:0]      cell_row;
    logic [CNT_W-1:0]      cell_col;
    logic                  done;
    logic [COORD_W-1:0]    pos_x;
    logic [COORD_W-1:0]    pos_y;
    logic [1:0]            status;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        status_t            code;
    } position_t;

    cfg_t      grid;
    position_t pending_pos[$];
    int        error_count;
    int        idle_cycles;
    logic      timed_out;

    three_point_grid_position dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .done      (done),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // one coordinate, exact rational truncated toward zero, then clamped
    function automatic logic [COORD_W-1:0] axis_pos(input longint base, input longint col_end,
        input longint row_end, input longint r, input longint c, inout logic clamped);
        longint rs;
        longint cs;
        longint den;
        longint num;
        longint q;
        rs  = longint'(grid.row_count) - 1;
        cs  = longint'(grid.col_count) - 1;
        den = rs * cs;
        num = base * den + r * (row_end - base) * cs + c * (col_end - base) * rs;
        q   = num / den;
        if (q < 0)
        begin
            clamped = 1'b1;
            return '0;
        end
        if (q > longint'({COORD_W{1'b1}}))
        begin
            clamped = 1'b1;
            return '1;
        end
        return q[COORD_W-1:0];
    endfunction

    function automatic position_t grid_position(input logic [CNT_W-1:0] r,
        input logic [CNT_W-1:0] c);
        position_t p;
        logic      clamped;
        p = '{x: '0, y: '0, code: ST_OK};
        clamped = 1'b0;
        if (grid.row_count < MIN_COUNT || grid.col_count < MIN_COUNT)
            p.code = ST_SMALL;
        else if (r >= grid.row_count || c >= grid.col_count)
            p.code = ST_OUTSIDE;
        else
        begin
            p.x = axis_pos(longint'(grid.origin_x), longint'(grid.col_corner_x),
                           longint'(grid.row_corner_x), longint'(r), longint'(c), clamped);
            p.y = axis_pos(longint'(grid.origin_y), longint'(grid.col_corner_y),
                           longint'(grid.row_corner_y), longint'(r), longint'(c), clamped);
            p.code = clamped ? ST_SAT : ST_OK;
        end
        return p;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        position_t want;
        if (rst_n && done)
        begin
            if (pending_pos.size() == 0)
                report("unexpected item", 0, 0);
            else
            begin
                want = pending_pos.pop_front();
                if (pos_x !== want.x)
                    report("pos_x", 32'(pos_x), 32'(want.x));
                if (pos_y !== want.y)
                    report("pos_y", 32'(pos_y), 32'(want.y));
                if (status !== want.code)
                    report("status", 32'(status), 32'(want.code));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || done || pending_pos.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT)
            timed_out <= 1'b1;
    end

    task automatic send_cell(input int r, input int c, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        cell_row <= CNT_W'(r);
        cell_col <= CNT_W'(c);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_pos.push_back(grid_position(CNT_W'(r), CNT_W'(c)));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_pos.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        logic [CFG_DATA_W-1:0] data;
        data      = CFG_DATA_W'(val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ROW_COUNT:    grid.row_count    = data[CNT_W-1:0];
            REG_COL_COUNT:    grid.col_count    = data[CNT_W-1:0];
            REG_ORIGIN_X:     grid.origin_x     = data;
            REG_ORIGIN_Y:     grid.origin_y     = data;
            REG_COL_CORNER_X: grid.col_corner_x = data;
            REG_COL_CORNER_Y: grid.col_corner_y = data;
            REG_ROW_CORNER_X: grid.row_corner_x = data;
            REG_ROW_CORNER_Y: grid.row_corner_y = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_grid(input int rows, input int cols, input int ox, input int oy,
        input int cx, input int cy, input int rx, input int ry);
        drain();
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COL_COUNT, cols);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_COL_CORNER_X, cx);
        write_reg(REG_COL_CORNER_Y, cy);
        write_reg(REG_ROW_CORNER_X, rx);
        write_reg(REG_ROW_CORNER_Y, ry);
    endtask

    task automatic test_reset_grid();
        send_cell(0, 0, 0);
        send_cell(1, 1, 0);
        send_cell(2, 0, 0);
    endtask

    task automatic test_directed();
        set_grid(255, 255, 0, 65535, 65535, 0, 65535, 65535);
        send_cell(0, 0, 0);
        send_cell(254, 0, 0);
        send_cell(0, 254, 0);
        send_cell(254, 254, 0);
        send_cell(255, 3, 0);
        send_cell(3, 255, 0);
        send_cell(127, 200, 0);
        set_grid(3, 7, 100, 40000, 0, 65535, 200, 0);
        send_cell(2, 6, 0);
        send_cell(1, 3, 0);
        send_cell(3, 0, 0);
        // unknown index is ignored
        drain();
        write_reg(4'd9, 32'h0000_ffff);
        write_reg(4'd15, 32'h0000_0000);
        send_cell(1, 5, 0);
        set_grid(1, 5, 1, 2, 3, 4, 5, 6);
        send_cell(0, 0, 0);
        set_grid(5, 0, 1, 2, 3, 4, 5, 6);
        send_cell(0, 0, 0);
        set_grid(2, 2, 65535, 65535, 0, 0, 0, 0);
        send_cell(1, 1, 0);
        send_cell(0, 1, 0);
    endtask

    task automatic test_random();
        int rows;
        int cols;
        int n;
        for (int phase = 0; phase < 30; phase++)
        begin
            rows = (phase % 10 == 0) ? $urandom_range(0, 255) :
                   (phase % 3 == 0) ? 255 : $urandom_range(2, 20);
            cols = (phase % 10 == 5) ? $urandom_range(0, 255) :
                   (phase % 4 == 0) ? 255 : $urandom_range(2, 20);
            set_grid(rows, cols, $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
            n = 0;
            while (n < 50)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_cell($urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 16));
                else
                    send_cell($urandom_range(0, rows > 0 ? rows - 1 : 0),
                              $urandom_range(0, cols > 0 ? cols - 1 : 0),
                              (n % 50 < 20) ? 0 : $urandom_range(0, 16));
                n++;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cell_row    = '0;
        cell_col    = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        error_count = 0;
        idle_cycles = 0;
        timed_out   = 1'b0;
        grid = '{row_count: 2, col_count: 2, default: '0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            begin
                test_reset_grid();
                test_directed();
                test_random();
                drain();
            end
            wait (timed_out);
        join_any
        if (timed_out)
            $display("[three_point_grid_position] ERROR");
        else if (error_count == 0)
            $display("[three_point_grid_position] OK");
        else
            $display("[three_point_grid_position] ERROR");
        $finish;
    end

endmodule
